/* rtl/sfia_pkg.sv */
// -----------------------------------------------------------------------------
// sfia_pkg: shared types and constants for the slab free-index allocator
// Field widths of the request/response words, command codes, configuration
// register indexes and their reset values.
// -----------------------------------------------------------------------------
`default_nettype none

package sfia_pkg;

	// Word field widths
	localparam int CMD_W     = 2;
	localparam int IDX_W     = 8;
	localparam int CACHED_W  = 7;
	localparam int IN_USE_W  = 9;

	// Configuration register widths
	localparam int OBJ_CFG_W   = 9;
	localparam int CAP_CFG_W   = 7;
	localparam int BATCH_W     = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 9;

	// Default sizes
	localparam int MAX_OBJECTS_DEF = 256;
	localparam int STACK_DEPTH_DEF = 128;

	// Upper bound on indices moved by one refill
	localparam int INACTIVE_BATCH = 12;

	// Register reset values
	localparam logic [OBJ_CFG_W-1:0] OBJ_CFG_RST   = 9'd256;
	localparam logic [CAP_CFG_W-1:0] CAP_CFG_RST   = 7'd120;
	localparam logic [BATCH_W-1:0]   BATCH_CFG_RST = 6'd60;

	// Commands
	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_REBUILD = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OBJECT_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CACHE_CAPACITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_BATCH = 2'd2;

endpackage

`default_nettype wire

/* rtl/sfia_ifs.sv */
// -----------------------------------------------------------------------------
// sfia channel interfaces
// Request and response channels of the allocator, valid/ready handshake.
// -----------------------------------------------------------------------------
`default_nettype none

interface sfia_req_if;
	logic                       valid;
	logic                       ready;
	logic [sfia_pkg::CMD_W-1:0] cmd;
	logic [sfia_pkg::IDX_W-1:0] free_index;

	modport source (output valid, output cmd, output free_index, input ready);
	modport sink   (input valid, input cmd, input free_index, output ready);
endinterface

interface sfia_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          granted;
	logic [sfia_pkg::IDX_W-1:0]    alloc_index;
	logic [sfia_pkg::CACHED_W-1:0] cached_count;
	logic [sfia_pkg::IN_USE_W-1:0] slab_in_use;

	modport source (output valid, output granted, output alloc_index,
		output cached_count, output slab_in_use, input ready);
	modport sink   (input valid, input granted, input alloc_index,
		input cached_count, input slab_in_use, output ready);
endinterface

`default_nettype wire

/* rtl/sfia_ram.sv */
// -----------------------------------------------------------------------------
// sfia_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// -----------------------------------------------------------------------------
`default_nettype none

module sfia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/slab_free_index_allocator.sv */
// -----------------------------------------------------------------------------
// slab_free_index_allocator: object-index allocator for one slab
// Free indices live in a linked chain (next-free RAM) and a front stack of
// cached indices (stack RAM). Allocs pop the stack, refilling from the chain
// when empty; frees push, flushing a batch back to the chain when full.
// -----------------------------------------------------------------------------
//
//  Port      Dir  Handshake       Word
//  --------  ---  --------------  ------------------------------------------
//  req       in   valid/ready     cmd, free_index
//  rsp       out  valid/ready     granted, alloc_index, cached_count,
//                                 slab_in_use
//  cfg_*     in   write enable    cfg_index, cfg_wdata (no read-back)
//
// Alloc from a non-empty stack and free without flush go from S_IDLE straight
// to S_DONE. An alloc on an empty stack first refills the stack, one next-free
// RAM read per index (S_REFILL_RD, S_REFILL_WR), at most 12 indices. A free on
// a full stack first flushes a batch, one stack RAM read per index (S_FLUSH_RD,
// S_FLUSH_WR). Rebuild sweeps the whole next-free RAM. After reset a sweep
// writes the chain into the next-free RAM; req.ready stays low until it ends.
// One word is in work at a time; a finished word waits in the output register
// while the next is accepted.
// -----------------------------------------------------------------------------
`default_nettype none

module slab_free_index_allocator #(
	parameter int MAX_OBJECTS = sfia_pkg::MAX_OBJECTS_DEF,
	parameter int STACK_DEPTH = sfia_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sfia_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sfia_pkg::CFG_DATA_W-1:0] cfg_wdata,
	sfia_req_if.sink                             req,
	sfia_rsp_if.source                           rsp
);

	import sfia_pkg::*;

	localparam int IW     = $clog2(MAX_OBJECTS);
	localparam int SAW    = $clog2(STACK_DEPTH);
	localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);
	localparam int FILL_W = $clog2(STACK_DEPTH + 1);
	localparam int OC_W   = (CNT_W > OBJ_CFG_W) ? CNT_W : OBJ_CFG_W;
	localparam int CC_W   = (FILL_W > CAP_CFG_W) ? FILL_W : CAP_CFG_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_REFILL_RD,
		S_REFILL_WR,
		S_FLUSH_RD,
		S_FLUSH_WR,
		S_DONE
	} state_t;

	state_t state_q;

	logic [OBJ_CFG_W-1:0] obj_cfg_q;
	logic [CAP_CFG_W-1:0] cap_cfg_q;
	logic [BATCH_W-1:0]   batch_cfg_q;

	logic [IW-1:0]     head_q;
	logic [CNT_W-1:0]  taken_q;
	logic [FILL_W-1:0] fill_q;
	logic [IW-1:0]     sweep_q;
	logic [IW-1:0]     term_q;
	logic              rebuild_q;
	logic [BATCH_W-1:0] want_q;
	logic [BATCH_W-1:0] left_q;
	logic [IW-1:0]     fidx_q;
	logic              res_granted_q;

	logic                rsp_valid_q;
	logic                rsp_granted_q;
	logic [IDX_W-1:0]    rsp_index_q;
	logic [CACHED_W-1:0] rsp_cached_q;
	logic [IN_USE_W-1:0] rsp_in_use_q;

	// effective register values
	logic [CNT_W-1:0]   n_eff;
	logic [FILL_W-1:0]  cap_eff;
	logic [BATCH_W-1:0] batch_eff;
	logic [BATCH_W-1:0] want_init;
	logic [OC_W-1:0]    obj_ext;
	logic [CC_W-1:0]    cap_ext;
	logic [CC_W-1:0]    cap_eff_ext;

	// control
	logic              accept;
	cmd_t              cmd;
	logic              fidx_ok;
	logic              stack_full;
	logic              flush_need;
	logic              refill_go;
	logic              flush_go;
	logic [FILL_W-1:0] fill_m1;
	logic [IW-1:0]     chain_val;
	logic              out_free;

	// RAM ports
	logic              s_we, s_re;
	logic [IW-1:0]     s_wdata, s_rdata;
	logic              n_we, n_re;
	logic [IW-1:0]     n_waddr, n_wdata, n_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_cfg_q   <= OBJ_CFG_RST;
			cap_cfg_q   <= CAP_CFG_RST;
			batch_cfg_q <= BATCH_CFG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OBJECT_COUNT:   obj_cfg_q   <= cfg_wdata[OBJ_CFG_W-1:0];
				REG_CACHE_CAPACITY: cap_cfg_q   <= cfg_wdata[CAP_CFG_W-1:0];
				REG_TRANSFER_BATCH: batch_cfg_q <= cfg_wdata[BATCH_W-1:0];
				default: ;
			endcase
		end
	end

	// saturate registers to their usable ranges
	always_comb begin
		obj_ext     = OC_W'(obj_cfg_q);
		cap_ext     = CC_W'(cap_cfg_q);
		if (obj_cfg_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (obj_ext > OC_W'(MAX_OBJECTS)) begin
			n_eff = CNT_W'(MAX_OBJECTS);
		end else begin
			n_eff = CNT_W'(obj_ext);
		end
		if (cap_cfg_q == '0) begin
			cap_eff = FILL_W'(1);
		end else if (cap_ext > CC_W'(STACK_DEPTH)) begin
			cap_eff = FILL_W'(STACK_DEPTH);
		end else begin
			cap_eff = FILL_W'(cap_ext);
		end
		cap_eff_ext = CC_W'(cap_eff);
		if (batch_cfg_q == '0) begin
			batch_eff = BATCH_W'(1);
		end else if (CC_W'(batch_cfg_q) > cap_eff_ext) begin
			batch_eff = BATCH_W'(cap_eff_ext);
		end else begin
			batch_eff = batch_cfg_q;
		end
		if ({1'b0, batch_eff} > (BATCH_W + 1)'(INACTIVE_BATCH)) begin
			want_init = BATCH_W'(INACTIVE_BATCH);
		end else begin
			want_init = batch_eff;
		end
	end

	// decode and loop conditions
	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign cmd        = cmd_t'(req.cmd);
	assign fidx_ok    = (OC_W'(req.free_index) < OC_W'(n_eff));
	assign stack_full = (fill_q >= FILL_W'(STACK_DEPTH));
	assign flush_need = (fill_q >= cap_eff);
	assign refill_go  = (want_q != '0) && (taken_q < n_eff) && !stack_full;
	assign flush_go   = (left_q != '0) && (fill_q != '0);
	assign fill_m1    = fill_q - FILL_W'(1);
	assign out_free   = !rsp_valid_q || rsp.ready;

	// chain entry written by the sweep
	always_comb begin
		if (sweep_q == term_q || sweep_q == IW'(MAX_OBJECTS - 1)) begin
			chain_val = '0;
		end else begin
			chain_val = sweep_q + IW'(1);
		end
	end

	// stack RAM control
	always_comb begin
		s_we    = 1'b0;
		s_re    = 1'b0;
		s_wdata = fidx_q;
		case (state_q)
			S_IDLE: begin
				s_wdata = IW'(req.free_index);
				s_we    = accept && (cmd == CMD_FREE) && fidx_ok && !flush_need && !stack_full;
				s_re    = accept && (cmd == CMD_ALLOC) && (fill_q != '0);
			end
			S_REFILL_RD: begin
				s_wdata = head_q;
				s_we    = refill_go;
				s_re    = !refill_go && (fill_q != '0);
			end
			S_FLUSH_RD: begin
				s_we = !flush_go && !stack_full;
				s_re = flush_go;
			end
			default: ;
		endcase
	end

	// next-free RAM control
	always_comb begin
		n_we    = (state_q == S_CLEAR) || (state_q == S_FLUSH_WR);
		n_waddr = (state_q == S_CLEAR) ? sweep_q : s_rdata;
		n_wdata = (state_q == S_CLEAR) ? chain_val : head_q;
		n_re    = (state_q == S_REFILL_RD) && refill_go;
	end

	sfia_ram #(
		.WIDTH (IW),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (fill_q[SAW-1:0]),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (fill_m1[SAW-1:0]),
		.rdata (s_rdata)
	);

	sfia_ram #(
		.WIDTH (IW),
		.DEPTH (MAX_OBJECTS)
	) u_next_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.re    (n_re),
		.raddr (head_q),
		.rdata (n_rdata)
	);

	// sequencer, allocator state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			head_q        <= '0;
			taken_q       <= '0;
			fill_q        <= '0;
			sweep_q       <= '0;
			term_q        <= IW'(MAX_OBJECTS - 1);
			rebuild_q     <= 1'b0;
			want_q        <= '0;
			left_q        <= '0;
			fidx_q        <= '0;
			res_granted_q <= 1'b0;
			rsp_valid_q   <= 1'b0;
			rsp_granted_q <= 1'b0;
			rsp_index_q   <= '0;
			rsp_cached_q  <= '0;
			rsp_in_use_q  <= '0;
		end else begin
			// word taken by the receiver; a new one loads in S_DONE
			if (rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				// write the chain, one entry a cycle
				S_CLEAR: begin
					if (sweep_q == IW'(MAX_OBJECTS - 1)) begin
						sweep_q <= '0;
						state_q <= rebuild_q ? S_DONE : S_IDLE;
					end else begin
						sweep_q <= sweep_q + IW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						fidx_q        <= IW'(req.free_index);
						res_granted_q <= 1'b0;
						state_q       <= S_DONE;
						case (cmd)
							CMD_ALLOC: begin
								if (fill_q != '0) begin
									fill_q        <= fill_m1;
									res_granted_q <= 1'b1;
								end else begin
									want_q  <= want_init;
									state_q <= S_REFILL_RD;
								end
							end
							CMD_FREE: begin
								if (fidx_ok) begin
									if (flush_need) begin
										left_q  <= batch_eff;
										state_q <= S_FLUSH_RD;
									end else if (!stack_full) begin
										fill_q <= fill_q + FILL_W'(1);
									end
								end
							end
							CMD_REBUILD: begin
								term_q    <= IW'(n_eff - CNT_W'(1));
								head_q    <= '0;
								taken_q   <= '0;
								fill_q    <= '0;
								rebuild_q <= 1'b1;
								state_q   <= S_CLEAR;
							end
							default: ;
						endcase
					end
				end
				// move head of chain onto the stack, then pop
				S_REFILL_RD: begin
					if (refill_go) begin
						fill_q  <= fill_q + FILL_W'(1);
						taken_q <= taken_q + CNT_W'(1);
						want_q  <= want_q - BATCH_W'(1);
						state_q <= S_REFILL_WR;
					end else begin
						if (fill_q != '0) begin
							fill_q        <= fill_m1;
							res_granted_q <= 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_REFILL_WR: begin
					head_q  <= n_rdata;
					state_q <= S_REFILL_RD;
				end
				// return stack top to chain head, then push
				S_FLUSH_RD: begin
					if (flush_go) begin
						fill_q  <= fill_m1;
						left_q  <= left_q - BATCH_W'(1);
						state_q <= S_FLUSH_WR;
					end else begin
						if (!stack_full) begin
							fill_q <= fill_q + FILL_W'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_FLUSH_WR: begin
					head_q <= s_rdata;
					if (taken_q != '0) begin
						taken_q <= taken_q - CNT_W'(1);
					end
					state_q <= S_FLUSH_RD;
				end
				// hand the result to the output register
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q   <= 1'b1;
						rsp_granted_q <= res_granted_q;
						rsp_index_q   <= res_granted_q ? IDX_W'(s_rdata) : '0;
						rsp_cached_q  <= CACHED_W'(fill_q);
						rsp_in_use_q  <= IN_USE_W'(taken_q);
						rebuild_q     <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.granted      = rsp_granted_q;
	assign rsp.alloc_index  = rsp_index_q;
	assign rsp.cached_count = rsp_cached_q;
	assign rsp.slab_in_use  = rsp_in_use_q;

endmodule

`default_nettype wire
